### hw/rtl/block_device_tag_controller_top_defines.svh
// Assertion macros shared by the tag controller RTL.
`ifndef BLOCK_DEVICE_TAG_CONTROLLER_TOP_DEFINES_SVH
`define BLOCK_DEVICE_TAG_CONTROLLER_TOP_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define BDTC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Same-cycle implication checked outside reset.
`define BDTC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bdtc_pkg.sv
// Types, register map and helpers shared by the tag controller modules.
package bdtc_pkg;

  localparam int unsigned TAG_W   = 6;
  localparam int unsigned IN_W    = 80;
  localparam int unsigned OUT_W   = 208;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [TAG_W-1:0] tag_t;

  typedef enum logic [1:0] {
    FUNC_RD   = 2'd0,
    FUNC_WR   = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  // Bus register map, byte offsets
  localparam logic [4:0] OFS_ADDR      = 5'd0;
  localparam logic [4:0] OFS_SECTOR    = 5'd8;
  localparam logic [4:0] OFS_LENGTH    = 5'd12;
  localparam logic [4:0] OFS_WRITE     = 5'd16;
  localparam logic [4:0] OFS_REQUEST   = 5'd17;
  localparam logic [4:0] OFS_NREQUEST  = 5'd18;
  localparam logic [4:0] OFS_COMPLETE  = 5'd19;
  localparam logic [4:0] OFS_NCOMPLETE = 5'd20;
  localparam logic [4:0] OFS_NSECTORS  = 5'd24;
  localparam logic [4:0] OFS_MAXLEN    = 5'd28;

  localparam logic [63:0] MAX_REQ_SECTORS = 64'd16;
  localparam logic [3:0]  MAX_BYTES       = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS = 2'd1;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic load;       // capture the input word
    logic commit;     // execute the captured word and load the result
    logic init_busy;  // idle tag FIFO fill in progress
    logic init_push;
    tag_t init_tag;
  } cmd_t;

  typedef struct packed {
    logic out_free;   // result register empty or being drained
  } status_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

### hw/rtl/bdtc_fifo.sv
// Tag FIFO with a small memory and a registered head read.
`include "block_device_tag_controller_top_defines.svh"

module bdtc_fifo import bdtc_pkg::*; #(
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tag_t          push_tag_i,
  input  logic          pop_i,
  output tag_t          head_tag_o,
  output logic [CW-1:0] count_o
);

  tag_t          mem [DEPTH];
  tag_t          head_q;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    cnt_d    = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Head is read every cycle; the pointer settles before the registered head is used.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_tag_i;
    end
    head_q <= mem[rd_ptr_q];
  end

  assign head_tag_o = head_q;
  assign count_o    = cnt_q;

  `BDTC_ASSERT_IMPL(a_no_pop_empty, pop_i, cnt_q != '0, "pop from empty tag FIFO")
  `BDTC_ASSERT_IMPL(a_no_push_full, push_i && !pop_i, cnt_q != CW'(DEPTH), "push to full tag FIFO")
  `BDTC_ASSERT(a_count_range, cnt_q <= CW'(DEPTH), "tag FIFO count out of range")

endmodule

### hw/rtl/bdtc_ctrl.sv
// Sequencer: idle FIFO fill after reset, word capture and execute handshake.
module bdtc_ctrl import bdtc_pkg::*; #(
  parameter int unsigned TAG_COUNT = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam int unsigned IW = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;

  ctrl_state_e   state_q, state_d;
  logic [IW-1:0] init_cnt_q, init_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      init_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d    = state_q;
    init_cnt_d = init_cnt_q;
    case (state_q)
      ST_INIT: begin
        init_cnt_d = init_cnt_q + 1'b1;
        if (init_cnt_q == IW'(TAG_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.init_tag  = tag_t'(init_cnt_q);
    case (state_q)
      ST_INIT: begin
        cmd_o.init_busy = 1'b1;
        cmd_o.init_push = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        // hold until the result register can take the word
        cmd_o.commit = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/bdtc_datapath.sv
// Request registers, tag FIFOs, tick counter and result register.
`include "block_device_tag_controller_top_defines.svh"

module bdtc_datapath import bdtc_pkg::*; #(
  parameter int unsigned TAG_COUNT = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic [IN_W-1:0]      in_data_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_W-1:0]     out_data_o
);

  localparam int unsigned CW = $clog2(TAG_COUNT + 1);

  // captured input word
  logic [1:0]  func_q;
  logic [4:0]  ofs_q;
  logic [63:0] wdata_q;
  logic [3:0]  nbytes_q;

  // configuration
  logic [15:0] lat_q;
  logic [31:0] nsec_q;

  // architectural state
  logic [63:0] addr_q, addr_d;
  logic [31:0] sector_q, sector_d;
  logic [31:0] length_q, length_d;
  logic        dir_q, dir_d;
  logic [15:0] tick_q, tick_d;
  logic        irq_q, irq_d;

  // result register
  logic        out_valid_q;
  logic [63:0] out_rd_q, rd;
  logic        out_ok_q, ok;
  logic        out_fault_q, fault;
  logic        out_irq_q;
  logic        out_iv_q, iv;
  logic [63:0] out_iaddr_q, iaddr;
  logic [31:0] out_isec_q, isec;
  logic [31:0] out_ilen_q, ilen;
  logic        out_iw_q, iw;
  tag_t        out_itag_q, itag;

  // FIFO interfaces
  logic          idle_push, idle_pop, pend_push, pend_pop, done_push, done_pop;
  tag_t          idle_push_tag, idle_head, pend_head, done_head;
  logic [CW-1:0] idle_cnt, pend_cnt, done_cnt;

  logic [63:0] mask;
  logic [16:0] tick_inc;
  logic        tick_wrap;

  bdtc_fifo #(.DEPTH(TAG_COUNT)) u_idle_fifo (
    .clk_i, .rst_ni,
    .push_i(idle_push), .push_tag_i(idle_push_tag), .pop_i(idle_pop),
    .head_tag_o(idle_head), .count_o(idle_cnt)
  );

  bdtc_fifo #(.DEPTH(TAG_COUNT)) u_pend_fifo (
    .clk_i, .rst_ni,
    .push_i(pend_push), .push_tag_i(idle_head), .pop_i(pend_pop),
    .head_tag_o(pend_head), .count_o(pend_cnt)
  );

  bdtc_fifo #(.DEPTH(TAG_COUNT)) u_done_fifo (
    .clk_i, .rst_ni,
    .push_i(done_push), .push_tag_i(pend_head), .pop_i(done_pop),
    .head_tag_o(done_head), .count_o(done_cnt)
  );

  assign mask      = byte_mask(nbytes_q);
  assign tick_inc  = {1'b0, tick_q} + 17'd1;
  assign tick_wrap = tick_inc >= {1'b0, lat_q};

  always_comb begin
    rd = '0; ok = 1'b0; fault = 1'b0;
    iv = 1'b0; iaddr = '0; isec = '0; ilen = '0; iw = 1'b0; itag = '0;
    addr_d = addr_q; sector_d = sector_q; length_d = length_q; dir_d = dir_q;
    tick_d = tick_q; irq_d = irq_q;
    idle_pop = 1'b0; pend_push = 1'b0; pend_pop = 1'b0;
    done_push = 1'b0; done_pop = 1'b0;
    idle_push     = cmd_i.init_push;
    idle_push_tag = cmd_i.init_tag;
    if (cmd_i.commit) begin
      case (func_q)
        FUNC_RD: begin
          if (nbytes_q <= MAX_BYTES) begin
            ok = 1'b1;
            case (ofs_q)
              OFS_REQUEST: begin
                if (idle_cnt != '0) begin
                  idle_pop  = 1'b1;
                  pend_push = 1'b1;
                end else begin
                  fault = 1'b1;
                end
              end
              OFS_NREQUEST:  rd = 64'(idle_cnt);
              OFS_COMPLETE: begin
                if (done_cnt != '0) begin
                  rd            = 64'(done_head);
                  done_pop      = 1'b1;
                  idle_push     = 1'b1;
                  idle_push_tag = done_head;
                  if (done_cnt == CW'(1)) begin
                    irq_d = 1'b0;
                  end
                end else begin
                  fault = 1'b1;
                end
              end
              OFS_NCOMPLETE: rd = 64'(done_cnt);
              OFS_NSECTORS:  rd = 64'(nsec_q);
              OFS_MAXLEN:    rd = MAX_REQ_SECTORS;
              default:       ok = 1'b0;
            endcase
            rd = rd & mask;
          end
        end
        FUNC_WR: begin
          if (nbytes_q <= MAX_BYTES) begin
            ok = 1'b1;
            case (ofs_q)
              OFS_ADDR:   addr_d   = (addr_q & ~mask) | (wdata_q & mask);
              OFS_SECTOR: sector_d = (sector_q & ~mask[31:0]) | (wdata_q[31:0] & mask[31:0]);
              OFS_LENGTH: length_d = (length_q & ~mask[31:0]) | (wdata_q[31:0] & mask[31:0]);
              OFS_WRITE: begin
                if (nbytes_q != 4'd0) begin
                  dir_d = wdata_q[0];
                end
              end
              default: ok = 1'b0;
            endcase
          end
        end
        FUNC_TICK: begin
          tick_d = tick_wrap ? 16'd0 : tick_inc[15:0];
          // complete the oldest pending tag at each wrap
          if (tick_wrap && pend_cnt != '0) begin
            iv        = 1'b1;
            iaddr     = addr_q;
            isec      = sector_q;
            ilen      = length_q;
            iw        = dir_q;
            itag      = pend_head;
            irq_d     = 1'b1;
            pend_pop  = 1'b1;
            done_push = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q       <= 16'd1;
      nsec_q      <= '0;
      addr_q      <= '0;
      sector_q    <= '0;
      length_q    <= '0;
      dir_q       <= 1'b0;
      tick_q      <= '0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_LATENCY: lat_q  <= cfg_data_i[15:0];
          CFG_SECTORS: nsec_q <= cfg_data_i;
          default: ;
        endcase
      end
      addr_q   <= addr_d;
      sector_q <= sector_d;
      length_q <= length_d;
      dir_q    <= dir_d;
      tick_q   <= tick_d;
      irq_q    <= irq_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= in_data_i[1:0];
      ofs_q    <= in_data_i[6:2];
      wdata_q  <= in_data_i[70:7];
      nbytes_q <= in_data_i[74:71];
    end
    if (cmd_i.commit) begin
      out_rd_q    <= rd;
      out_ok_q    <= ok;
      out_fault_q <= fault;
      out_irq_q   <= irq_d;
      out_iv_q    <= iv;
      out_iaddr_q <= iaddr;
      out_isec_q  <= isec;
      out_ilen_q  <= ilen;
      out_iw_q    <= iw;
      out_itag_q  <= itag;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o = {5'd0, out_itag_q, out_iw_q, out_ilen_q, out_isec_q, out_iaddr_q,
                       out_iv_q, out_irq_q, out_fault_q, out_ok_q, out_rd_q};

  `BDTC_ASSERT(a_irq_tracks_done, irq_q == (done_cnt != '0), "irq disagrees with completion FIFO")
  `BDTC_ASSERT_IMPL(a_tags_conserved, !cmd_i.init_busy, (32'(idle_cnt) + 32'(pend_cnt) + 32'(done_cnt)) == 32'(TAG_COUNT), "tag lost or duplicated")
  `BDTC_ASSERT_IMPL(a_fault_decoded, out_valid_q && out_fault_q, out_ok_q, "fault on undecoded access")
  `BDTC_ASSERT_IMPL(a_issue_raises_irq, out_valid_q && out_iv_q, out_irq_q, "issued command without irq")

endmodule

### hw/rtl/block_device_tag_controller_top.sv
// Top level of the block-device request tag controller.
// Each bus read, bus write or tick word is first captured, while the three
// tag FIFO memories present their registered head entries, and then
// executed, which loads the result register. The next word is taken
// while a result still waits on the master side, but it executes only once
// that result has been taken. After reset the idle tag FIFO is filled with
// tags 0 to TAG_COUNT-1, one per cycle, and s_axis_tready stays low until
// the fill is done; configuration writes are taken at any time.
module block_device_tag_controller_top import bdtc_pkg::*; #(
  parameter int unsigned TAG_COUNT = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // func [1:0], reg_offset [6:2], wr_data [70:7], byte_count [74:71], zero pad
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // rd_data [63:0], access_ok [64], fault [65], irq_level [66], issue_valid [67],
  // issue_mem_addr [131:68], issue_sector [163:132], issue_sectors [195:164],
  // issue_is_write [196], issue_tag [202:197], zero pad
  output logic [OUT_W-1:0]     m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  bdtc_ctrl #(.TAG_COUNT(TAG_COUNT)) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  bdtc_datapath #(.TAG_COUNT(TAG_COUNT)) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

### dv/tb_block_device_tag_controller_top.sv
// Self-checking testbench for the block-device tag controller top level.
module tb_block_device_tag_controller_top;
  import bdtc_pkg::*;

  localparam int unsigned TAGS      = 4;
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned PHASE_LEN = 180;
  localparam int unsigned HOLD_LEN  = 400;
  localparam logic [1:0]  FUNC_BAD  = 2'd3;

  typedef struct packed {
    logic [4:0]  pad;
    logic [3:0]  nbytes;
    logic [63:0] wdata;
    logic [4:0]  ofs;
    logic [1:0]  func;
  } access_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [5:0]  tag;
    logic        is_wr;
    logic [31:0] sectors;
    logic [31:0] sector;
    logic [63:0] addr;
    logic        issue;
    logic        irq;
    logic        fault;
    logic        ok;
    logic [63:0] rd;
  } resp_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  ofs;
    logic [63:0] wdata;
    logic [3:0]  nbytes;
    logic        pin;
    logic [63:0] rd;
    logic        ok;
    logic        fault;
    logic        irq;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;

  block_device_tag_controller_top #(.TAG_COUNT(TAGS)) dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the controller
  tag_t        idle_q[$], queued_q[$], done_q[$];
  logic [63:0] sh_addr;
  logic [31:0] sh_sector, sh_length;
  logic        sh_dir, sh_irq;
  logic [15:0] sh_ticks, sh_latency;
  logic [31:0] sh_nsectors;

  resp_t       resp_due_q[$];
  int unsigned fail_cnt = 0;
  int unsigned n_sent = 0;
  int unsigned cyc = 0;
  logic        hold_rx = 1'b0;
  bit          tx_burst = 1'b0, rx_burst = 1'b0;

  row_t dir_tab [0:26] = '{
    '{FUNC_RD,   OFS_MAXLEN,    64'h0,     4'd8,  1'b1, 64'd16, 1'b1, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_NREQUEST,  64'h0,     4'd8,  1'b1, 64'd4,  1'b1, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_NSECTORS,  64'h0,     4'd4,  1'b1, 64'd0,  1'b1, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_COMPLETE,  64'h0,     4'd8,  1'b1, 64'd0,  1'b1, 1'b1, 1'b0},
    '{FUNC_RD,   5'd5,          64'h0,     4'd8,  1'b1, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_ADDR,      64'h0,     4'd8,  1'b1, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_WR,   OFS_REQUEST,   '1,        4'd8,  1'b1, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_MAXLEN,    64'h0,     4'd9,  1'b1, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_BAD,  OFS_MAXLEN,    64'h0,     4'd8,  1'b1, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_MAXLEN,    64'h0,     4'd0,  1'b1, 64'd0,  1'b1, 1'b0, 1'b0},
    '{FUNC_WR,   OFS_ADDR,      '1,        4'd8,  1'b1, 64'd0,  1'b1, 1'b0, 1'b0},
    '{FUNC_WR,   OFS_ADDR,      64'h0,     4'd3,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_WR,   OFS_SECTOR,    64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 64'd0, 1'b0, 1'b0, 1'b0},
    '{FUNC_WR,   OFS_LENGTH,    64'hFFFF_FFFF_FFFF_0010, 4'd2, 1'b0, 64'd0, 1'b0, 1'b0, 1'b0},
    '{FUNC_WR,   OFS_WRITE,     64'h1,     4'd0,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_WR,   OFS_WRITE,     '1,        4'd1,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_REQUEST,   64'h0,     4'd8,  1'b1, 64'd0,  1'b1, 1'b0, 1'b0},
    '{FUNC_TICK, 5'd31,         '1,        4'd15, 1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_NCOMPLETE, 64'h0,     4'd1,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_REQUEST,   64'h0,     4'd8,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_REQUEST,   64'h0,     4'd8,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_REQUEST,   64'h0,     4'd8,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_REQUEST,   64'h0,     4'd8,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_TICK, 5'd0,          64'h0,     4'd0,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_COMPLETE,  64'h0,     4'd1,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_COMPLETE,  64'h0,     4'd0,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0},
    '{FUNC_RD,   OFS_COMPLETE,  64'h0,     4'd8,  1'b0, 64'd0,  1'b0, 1'b0, 1'b0}
  };

  function automatic logic [63:0] byte_lanes(logic [3:0] n);
    if (n >= 4'd8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // Execute one access on the shadow state and return the response word
  function automatic resp_t exec_access(access_t a);
    resp_t       r;
    logic [63:0] m;
    logic [16:0] nxt;
    tag_t        t;
    r = '0;
    m = byte_lanes(a.nbytes);
    if (a.func == FUNC_RD && a.nbytes <= MAX_BYTES) begin
      r.ok = 1'b1;
      case (a.ofs)
        OFS_REQUEST: begin
          if (idle_q.size() != 0) queued_q.push_back(idle_q.pop_front());
          else r.fault = 1'b1;
        end
        OFS_NREQUEST:  r.rd = 64'(idle_q.size());
        OFS_NCOMPLETE: r.rd = 64'(done_q.size());
        OFS_COMPLETE: begin
          if (done_q.size() != 0) begin
            t = done_q.pop_front();
            r.rd = 64'(t);
            idle_q.push_back(t);
            if (done_q.size() == 0) sh_irq = 1'b0;
          end else begin
            r.fault = 1'b1;
          end
        end
        OFS_NSECTORS:  r.rd = 64'(sh_nsectors);
        OFS_MAXLEN:    r.rd = MAX_REQ_SECTORS;
        default:       r.ok = 1'b0;
      endcase
      r.rd &= m;
    end else if (a.func == FUNC_WR && a.nbytes <= MAX_BYTES) begin
      r.ok = 1'b1;
      case (a.ofs)
        OFS_ADDR:   sh_addr = (sh_addr & ~m) | (a.wdata & m);
        OFS_SECTOR: sh_sector = (sh_sector & ~m[31:0]) | (a.wdata[31:0] & m[31:0]);
        OFS_LENGTH: sh_length = (sh_length & ~m[31:0]) | (a.wdata[31:0] & m[31:0]);
        OFS_WRITE:  if (a.nbytes != 4'd0) sh_dir = a.wdata[0];
        default:    r.ok = 1'b0;
      endcase
    end else if (a.func == FUNC_TICK) begin
      // wrap once the count reaches the period; a period of zero acts as one
      nxt = {1'b0, sh_ticks} + 17'd1;
      sh_ticks = (nxt >= {1'b0, sh_latency}) ? 16'd0 : nxt[15:0];
      if (sh_ticks == 16'd0 && queued_q.size() != 0) begin
        t         = queued_q.pop_front();
        r.issue   = 1'b1;
        r.addr    = sh_addr;
        r.sector  = sh_sector;
        r.sectors = sh_length;
        r.is_wr   = sh_dir;
        r.tag     = t;
        sh_irq    = 1'b1;
        done_q.push_back(t);
      end
    end
    r.irq = sh_irq;
    return r;
  endfunction

  function automatic access_t rand_access();
    access_t     a;
    int unsigned sel;
    logic [4:0]  rd_ofs [8] = '{OFS_REQUEST, OFS_REQUEST, OFS_COMPLETE, OFS_COMPLETE,
                                OFS_NREQUEST, OFS_NCOMPLETE, OFS_NSECTORS, OFS_MAXLEN};
    logic [4:0]  wr_ofs [4] = '{OFS_ADDR, OFS_SECTOR, OFS_LENGTH, OFS_WRITE};
    a = '0;
    a.wdata  = {$urandom, $urandom};
    a.nbytes = ($urandom_range(0, 15) == 0) ? 4'd0 : 4'($urandom_range(1, 8));
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      a.func   = FUNC_TICK;
      a.ofs    = 5'($urandom_range(0, 31));
      a.nbytes = 4'($urandom_range(0, 15));
    end else if (sel < 65) begin
      a.func = FUNC_RD;
      a.ofs  = rd_ofs[$urandom_range(0, 7)];
    end else if (sel < 88) begin
      a.func = FUNC_WR;
      a.ofs  = wr_ofs[$urandom_range(0, 3)];
    end else begin
      a.func   = 2'($urandom_range(0, 3));
      a.ofs    = 5'($urandom_range(0, 31));
      a.nbytes = 4'($urandom_range(0, 15));
    end
    return a;
  endfunction

  // Offer one word; pinned rows replace the computed response
  task automatic send_access(access_t a, bit pin, resp_t pinned);
    int unsigned gap;
    resp_t       r;
    if (n_sent % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= a;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    r = exec_access(a);
    resp_due_q.push_back(pin ? pinned : r);
    n_sent++;
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) send_access(rand_access(), 1'b0, '0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (resp_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == CFG_LATENCY) sh_latency = val[15:0];
    else if (idx == CFG_SECTORS) sh_nsectors = val;
  endtask

  task automatic cmp_field(string fld, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("mismatch %s: expected %h actual %h", fld, want, got);
    end
  endtask

  task automatic check_resp(logic [OUT_W-1:0] raw);
    resp_t got, want;
    got = raw;
    if (resp_due_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10) $display("unexpected response word %h", raw);
      return;
    end
    want = resp_due_q.pop_front();
    cmp_field("rd_data",        want.rd,      got.rd);
    cmp_field("access_ok",      want.ok,      got.ok);
    cmp_field("fault",          want.fault,   got.fault);
    cmp_field("irq_level",      want.irq,     got.irq);
    cmp_field("issue_valid",    want.issue,   got.issue);
    cmp_field("issue_mem_addr", want.addr,    got.addr);
    cmp_field("issue_sector",   want.sector,  got.sector);
    cmp_field("issue_sectors",  want.sectors, got.sectors);
    cmp_field("issue_is_write", want.is_wr,   got.is_wr);
    cmp_field("issue_tag",      want.tag,     got.tag);
  endtask

  // Response side
  initial begin
    int unsigned gap, n_recv;
    n_recv = 0;
    forever begin
      if (n_recv % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      while (hold_rx) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid === 1'b1 && rst_ni));
      check_resp(m_axis_tdata);
      n_recv++;
    end
  end

  // Long receiver stall so the block backs up into its input
  initial begin
    while (n_sent < 400) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("block_device_tag_controller_top verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] lat_set [6];
    logic [31:0] sec_set [6];
    resp_t       pinned;
    idle_q.delete();
    queued_q.delete();
    done_q.delete();
    for (int i = 0; i < TAGS; i++) idle_q.push_back(tag_t'(i));
    sh_addr = '0; sh_sector = '0; sh_length = '0; sh_dir = 1'b0; sh_irq = 1'b0;
    sh_ticks = '0; sh_latency = 16'd1; sh_nsectors = '0;

    lat_set = '{32'hFFFF_FFFF, 32'hABCD_0000, 32'd2, 32'd3, 32'd1,
                32'($urandom_range(1, 6))};
    sec_set = '{32'hFFFF_FFFF, 32'd0, $urandom, $urandom, $urandom, $urandom};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      pinned       = '0;
      pinned.rd    = dir_tab[i].rd;
      pinned.ok    = dir_tab[i].ok;
      pinned.fault = dir_tab[i].fault;
      pinned.irq   = dir_tab[i].irq;
      send_access('{pad: '0, nbytes: dir_tab[i].nbytes, wdata: dir_tab[i].wdata,
                    ofs: dir_tab[i].ofs, func: dir_tab[i].func},
                  dir_tab[i].pin, pinned);
    end
    run_random(PHASE_LEN);

    for (int p = 0; p < 6; p++) begin
      drain();
      cfg_write(CFG_LATENCY, lat_set[p]);
      cfg_write(CFG_SECTORS, sec_set[p]);
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
      run_random(PHASE_LEN);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("block_device_tag_controller_top verification clean");
    end else begin
      $display("block_device_tag_controller_top verification failed");
    end
    $finish;
  end

endmodule
